### hdl/multi_tone_internal_model_controller_assert.svh
// assertion macros shared by the controller rtl
`ifndef MULTI_TONE_INTERNAL_MODEL_CONTROLLER_ASSERT_SVH
`define MULTI_TONE_INTERNAL_MODEL_CONTROLLER_ASSERT_SVH

// clocked check, held off while reset is high
`define MTIMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define MTIMC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mtimc_pkg.sv
// types, constants and saturation helpers for the multi-tone controller
`default_nettype none

package mtimc_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 18;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned OPB_W     = 33;
  localparam int unsigned PROD_W    = GAIN_W + OPB_W;
  localparam int unsigned WIDE_W    = 36;
  localparam int unsigned ACC_W     = 34;
  localparam int unsigned NEG_W     = 35;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RND_W     = NEG_W - FRAC_W;
  localparam int unsigned REG_IDX_W = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DC_GAIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RES_GAIN_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TWOCOS_1   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRIVE,
    ST_DC_MUL,
    ST_DC_ADD,
    ST_GY_MUL,
    ST_RES_S,
    ST_FB_MUL,
    ST_RES_UPD
  } mtimc_state_t;

  // clamp a 36-bit value to the 32-bit state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [WIDE_W-1:0] v);
    logic same;
    same = (v[WIDE_W-1:STATE_W-1] == '0) || (v[WIDE_W-1:STATE_W-1] == '1);
    if (same) begin
      return v[STATE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // clamp a rounded drive value to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] sat_drive(input logic signed [RND_W-1:0] v);
    logic same;
    same = (v[RND_W-1:SAMPLE_W-1] == '0) || (v[RND_W-1:SAMPLE_W-1] == '1);
    if (same) begin
      return v[SAMPLE_W-1:0];
    end else if (v[RND_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### hdl/mtimc_mul.sv
// shared signed 18 x 33 multiplier with registered product
`default_nettype none

module mtimc_mul (
  input  wire logic                                 clk,
  input  wire logic signed [mtimc_pkg::GAIN_W-1:0]  a,
  input  wire logic signed [mtimc_pkg::OPB_W-1:0]   b,
  output      logic signed [mtimc_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

### hdl/multi_tone_internal_model_controller.sv
// multi-tone internal-model controller: integrator plus resonators on one multiplier
//
//   channel   dir  signals                         payload
//   s_axis    in   tvalid tready tdata[15:0]       error_sample
//   m_axis    out  tvalid tready tdata[15:0]       drive
//   cfg       in   cfg_wr_en cfg_index cfg_data    7 registers, 18-bit signed
//
// between one accepted transfer and the next, the sequencer takes the sample in idle,
// builds the output sum over the resonators, loads the drive, runs the integrator
// and then each resonator in turn on the shared multiplier.
// rst is synchronous and clears the sequencer, state and config registers to zero.
// the drive waits in an output register; a stall there holds the sequencer
// only when the next drive is ready and the register is still full.
`default_nettype none

module multi_tone_internal_model_controller #(
  parameter int unsigned RESONATORS = 3
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [mtimc_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [mtimc_pkg::GAIN_W-1:0]           cfg_data,
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  input  wire logic [mtimc_pkg::SAMPLE_W-1:0]         s_axis_tdata,  // [15:0] error_sample
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output      logic [mtimc_pkg::SAMPLE_W-1:0]         m_axis_tdata   // [15:0] drive
);

  localparam int unsigned RIW = (RESONATORS > 1) ? $clog2(RESONATORS) : 1;
  localparam logic [RIW-1:0] LAST_RES = RIW'(RESONATORS - 1);

  localparam int unsigned STATE_W = mtimc_pkg::STATE_W;
  localparam int unsigned WIDE_W  = mtimc_pkg::WIDE_W;
  localparam int unsigned OPB_W   = mtimc_pkg::OPB_W;
  localparam int unsigned PROD_W  = mtimc_pkg::PROD_W;
  localparam int unsigned ACC_W   = mtimc_pkg::ACC_W;
  localparam int unsigned NEG_W   = mtimc_pkg::NEG_W;
  localparam int unsigned FRAC_W  = mtimc_pkg::FRAC_W;
  localparam int unsigned RND_W   = mtimc_pkg::RND_W;
  localparam int unsigned GAIN_W  = mtimc_pkg::GAIN_W;
  localparam int unsigned SMP_W   = mtimc_pkg::SAMPLE_W;

  // configuration registers
  logic signed [GAIN_W-1:0] dc_gain;
  logic signed [GAIN_W-1:0] res_gain [RESONATORS];
  logic signed [GAIN_W-1:0] twocos   [RESONATORS];

  // controller state
  logic signed [STATE_W-1:0] dc_integrator;
  logic signed [STATE_W-1:0] osc_first  [RESONATORS];
  logic signed [STATE_W-1:0] osc_second [RESONATORS];

  mtimc_pkg::mtimc_state_t state, state_next;
  logic [RIW-1:0]           res_idx;
  logic signed [SMP_W-1:0]  sample;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OPB_W-1:0]  s_val;
  logic signed [STATE_W-1:0] old_first;

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic load_out;
  logic take_in;

  mtimc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  function automatic logic [mtimc_pkg::REG_IDX_W-1:0] REG_OFS(input int i);
    return i[mtimc_pkg::REG_IDX_W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_gain <= '0;
      for (int i = 0; i < RESONATORS; i++) begin
        res_gain[i] <= '0;
        twocos[i]   <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == mtimc_pkg::REG_DC_GAIN) begin
        dc_gain <= cfg_data;
      end
      for (int i = 0; i < RESONATORS; i++) begin
        if (cfg_index == mtimc_pkg::REG_RES_GAIN_1 + REG_OFS(i)) begin
          res_gain[i] <= cfg_data;
        end
        if (cfg_index == mtimc_pkg::REG_TWOCOS_1 + REG_OFS(i)) begin
          twocos[i] <= cfg_data;
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtimc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    load_out      = 1'b0;
    s_axis_tready = 1'b0;
    take_in       = 1'b0;
    unique case (state)
      mtimc_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          take_in    = 1'b1;
          state_next = mtimc_pkg::ST_SUM;
        end
      end
      mtimc_pkg::ST_SUM: begin
        if (res_idx == LAST_RES) begin
          state_next = mtimc_pkg::ST_DRIVE;
        end
      end
      mtimc_pkg::ST_DRIVE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = mtimc_pkg::ST_DC_MUL;
        end
      end
      mtimc_pkg::ST_DC_MUL:  state_next = mtimc_pkg::ST_DC_ADD;
      mtimc_pkg::ST_DC_ADD:  state_next = mtimc_pkg::ST_GY_MUL;
      mtimc_pkg::ST_GY_MUL:  state_next = mtimc_pkg::ST_RES_S;
      mtimc_pkg::ST_RES_S:   state_next = mtimc_pkg::ST_FB_MUL;
      mtimc_pkg::ST_FB_MUL:  state_next = mtimc_pkg::ST_RES_UPD;
      mtimc_pkg::ST_RES_UPD: begin
        state_next = (res_idx == LAST_RES) ? mtimc_pkg::ST_IDLE : mtimc_pkg::ST_GY_MUL;
      end
      default: state_next = mtimc_pkg::ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = dc_gain;
    mul_b = OPB_W'(sample);
    unique case (state)
      mtimc_pkg::ST_GY_MUL: mul_a = res_gain[res_idx];
      mtimc_pkg::ST_FB_MUL: begin
        mul_a = twocos[res_idx];
        mul_b = s_val;
      end
      default: begin
        mul_a = dc_gain;
        mul_b = OPB_W'(sample);
      end
    endcase
  end

  // datapath arithmetic
  logic signed [STATE_W-1:0] gy;
  logic signed [WIDE_W-1:0]  dc_sum;
  logic signed [OPB_W-1:0]   s_sum;
  logic signed [PROD_W-1:0]  fb_bias;
  logic signed [NEG_W-1:0]   fb_rnd;
  logic signed [WIDE_W-1:0]  second_sum;
  logic signed [NEG_W-1:0]   acc_neg;
  logic signed [NEG_W-1:0]   acc_bias;
  logic signed [SMP_W-1:0]   drive_val;

  always_comb begin
    gy         = mtimc_pkg::sat_state(mul_p[WIDE_W-1:0]);
    dc_sum     = WIDE_W'(dc_integrator) + WIDE_W'(gy);
    s_sum      = OPB_W'(osc_second[res_idx]) + OPB_W'(gy);
    // round to nearest, ties upward, then drop the fraction
    fb_bias    = mul_p + PROD_W'(1 << (FRAC_W - 1));
    fb_rnd     = fb_bias[PROD_W-1:FRAC_W];
    second_sum = WIDE_W'(fb_rnd) - WIDE_W'(old_first);
    acc_neg    = -NEG_W'(acc);
    acc_bias   = acc_neg + NEG_W'(1 << (FRAC_W - 1));
    drive_val  = mtimc_pkg::sat_drive(acc_bias[NEG_W-1:FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_idx       <= '0;
      dc_integrator <= '0;
      for (int i = 0; i < RESONATORS; i++) begin
        osc_first[i]  <= '0;
        osc_second[i] <= '0;
      end
    end else begin
      unique case (state)
        mtimc_pkg::ST_IDLE: begin
          res_idx <= '0;
        end
        mtimc_pkg::ST_SUM: begin
          res_idx <= (res_idx == LAST_RES) ? '0 : res_idx + 1'b1;
        end
        mtimc_pkg::ST_DC_ADD: begin
          dc_integrator <= mtimc_pkg::sat_state(dc_sum);
        end
        mtimc_pkg::ST_RES_S: begin
          s_val              <= s_sum;
          old_first          <= osc_first[res_idx];
          osc_first[res_idx] <= mtimc_pkg::sat_state(WIDE_W'(s_sum));
        end
        mtimc_pkg::ST_RES_UPD: begin
          osc_second[res_idx] <= mtimc_pkg::sat_state(second_sum);
          res_idx             <= (res_idx == LAST_RES) ? '0 : res_idx + 1'b1;
        end
        default: begin
          res_idx <= res_idx;
        end
      endcase
    end
  end

  // sample capture and the output sum
  always_ff @(posedge clk) begin
    if (take_in) begin
      sample <= s_axis_tdata;
      acc    <= ACC_W'(dc_integrator);
    end else if (state == mtimc_pkg::ST_SUM) begin
      acc    <= acc + ACC_W'(osc_first[res_idx]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= drive_val;
    end
  end

`include "multi_tone_internal_model_controller_assert.svh"

  `MTIMC_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
  `MTIMC_ASSERT(a_idx_range, res_idx <= LAST_RES, "resonator index out of range")
  `MTIMC_ASSERT(a_drive_loaded, load_out |=> m_axis_tvalid, "drive transfer not presented")
  `MTIMC_ASSERT(a_done_to_idle, (state == mtimc_pkg::ST_RES_UPD) && (res_idx == LAST_RES) |=> s_axis_tready, "sequencer did not return to idle")
  `MTIMC_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == mtimc_pkg::ST_IDLE) && !m_axis_tvalid, "reset did not clear control")

endmodule

`default_nettype wire
